// ----- src/tpt_pkg.sv -----
`default_nettype none

package tpt_pkg;

  // default counter widths
  localparam int unsigned DefLineWidth   = 24;
  localparam int unsigned DefColumnWidth = 16;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_CTRL = 2'd1;
  localparam logic [1:0] ERR_OPEN = 2'd2;

endpackage

`default_nettype wire

// ----- src/text_position_tracker_comment_strip.sv -----
// Comment stripper with line/column tracking.
// Latency: a byte's results are offered on the cycle after its request is taken.
// Throughput: one byte per cycle while out_ready_i is high; a byte that releases
// a held '/' together with a result of its own gives two results, and the
// two-entry output queue then holds off the next request while both are queued.
// Reset (rst_ni low, asynchronous): line 1, column 1, nothing held, queue empty.
`default_nettype none

module text_position_tracker_comment_strip #(
  parameter int unsigned LINE_WIDTH   = tpt_pkg::DefLineWidth,
  parameter int unsigned COLUMN_WIDTH = tpt_pkg::DefColumnWidth
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // byte request channel
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [7:0]              text_byte_i,
  // result request channel
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [7:0]                   char_out_o,
  output logic [LINE_WIDTH-1:0]        line_no_o,
  output logic [COLUMN_WIDTH-1:0]      column_no_o,
  output logic [1:0]                   error_code_o,
  output logic                         done_res_o,
  output logic                         last_of_run_o
);
  import tpt_pkg::*;

  localparam int unsigned LW = LINE_WIDTH;
  localparam int unsigned CW = COLUMN_WIDTH;

  // scanner modes
  localparam logic [2:0] M_NORMAL  = 3'd0;
  localparam logic [2:0] M_HSLASH  = 3'd1; // '/' held, may open a comment
  localparam logic [2:0] M_HCR     = 3'd2; // CR held, waiting for LF
  localparam logic [2:0] M_COMMENT = 3'd3;
  localparam logic [2:0] M_CSTAR   = 3'd4; // in comment, last byte was '*'
  localparam logic [2:0] M_CCR     = 3'd5; // CR inside a comment
  localparam logic [2:0] M_HALTED  = 3'd6; // error seen, silent until reset

  typedef struct packed {
    logic [7:0]    ch;
    logic [LW-1:0] line;
    logic [CW-1:0] col;
    logic [1:0]    err;
    logic          done;
    logic          last;
  } result_t;

  // ---------------------------------------------------------------------------
  // Scanner state
  // ---------------------------------------------------------------------------
  logic [2:0]    mode_q, mode_d;
  logic [LW-1:0] line_q, line_d;
  logic [CW-1:0] col_q, col_d;
  logic [LW-1:0] hline_q, hline_d;
  logic [CW-1:0] hcol_q, hcol_d;

  logic [7:0] b;
  assign b = text_byte_i;

  // Position arithmetic: line and column advances saturate at all-ones.
  logic [CW-1:0] col_p1, col_tab, col_adv;
  logic [LW-1:0] line_p1;
  logic [2:0]    tab_amt;
  logic [CW:0]   tab_sum;
  logic [CW-1:0] col_m1;
  logic          is_bad;

  always_comb begin
    col_p1  = (&col_q) ? col_q : col_q + {{(CW-1){1'b0}}, 1'b1};
    line_p1 = (&line_q) ? line_q : line_q + {{(LW-1){1'b0}}, 1'b1};
    // next tab stop 1,5,9,... : advance by 4 - ((col-1) mod 4)
    col_m1  = col_q - {{(CW-1){1'b0}}, 1'b1};
    tab_amt = 3'd4 - {1'b0, col_m1[1:0]};
    tab_sum = {1'b0, col_q} + {{(CW-2){1'b0}}, tab_amt};
    col_tab = tab_sum[CW] ? {CW{1'b1}} : tab_sum[CW-1:0];
    // UTF-8 continuation bytes (10xxxxxx) take no column
    col_adv = (b[7] && !b[6]) ? col_q : col_p1;
    is_bad  = (b < CH_SPACE && b != CH_TAB && b != CH_LF && b != CH_CR) ||
              b == CH_DEL;
  end

  // Handling of a byte in normal text, shared by the normal mode and by the
  // byte that follows a held '/' that did not open a comment.
  logic          nb_v;
  result_t       nb_r;
  logic [2:0]    nb_mode;
  logic [LW-1:0] nb_line, nb_hline;
  logic [CW-1:0] nb_col, nb_hcol;

  always_comb begin
    nb_v     = 1'b0;
    nb_r     = '{ch: b, line: line_q, col: col_q, err: ERR_NONE, done: 1'b0,
                 last: 1'b0};
    nb_mode  = M_NORMAL;
    nb_line  = line_q;
    nb_col   = col_q;
    nb_hline = hline_q;
    nb_hcol  = hcol_q;
    if (b == CH_NUL) begin
      // end of text: pass it on, restart position
      nb_v      = 1'b1;
      nb_r.done = 1'b1;
      nb_line   = {{(LW-1){1'b0}}, 1'b1};
      nb_col    = {{(CW-1){1'b0}}, 1'b1};
    end else if (b == CH_SLASH) begin
      nb_hline = line_q;
      nb_hcol  = col_q;
      nb_col   = col_p1;
      nb_mode  = M_HSLASH;
    end else if (b == CH_CR) begin
      nb_hline = line_q;
      nb_hcol  = col_q;
      nb_mode  = M_HCR;
    end else if (b == CH_LF) begin
      nb_v    = 1'b1;
      nb_line = line_p1;
      nb_col  = {{(CW-1){1'b0}}, 1'b1};
    end else if (b == CH_TAB) begin
      nb_v   = 1'b1;
      nb_col = col_tab;
    end else if (is_bad) begin
      nb_v      = 1'b1;
      nb_r.ch   = CH_NUL;
      nb_r.err  = ERR_CTRL;
      nb_r.done = 1'b1;
      nb_mode   = M_HALTED;
    end else begin
      nb_v   = 1'b1;
      nb_col = col_adv;
    end
  end

  // Per-byte results: up to two, slot 0 first.
  result_t    r0, r1;
  logic [1:0] n_res;

  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    hline_d = hline_q;
    hcol_d  = hcol_q;
    n_res   = 2'd0;
    r0      = nb_r;
    r1      = nb_r;

    unique case (mode_q)
      M_NORMAL: begin
        r0      = nb_r;
        n_res   = {1'b0, nb_v};
        mode_d  = nb_mode;
        line_d  = nb_line;
        col_d   = nb_col;
        hline_d = nb_hline;
        hcol_d  = nb_hcol;
      end
      M_HSLASH: begin
        if (b == CH_STAR) begin
          col_d  = col_p1;
          mode_d = M_CSTAR; // this '*' may also close the comment
        end else begin
          // release the slash at its own place, then the byte as usual
          r0 = '{ch: CH_SLASH, line: hline_q, col: hcol_q, err: ERR_NONE,
                 done: 1'b0, last: 1'b0};
          r1      = nb_r;
          n_res   = nb_v ? 2'd2 : 2'd1;
          mode_d  = nb_mode;
          line_d  = nb_line;
          col_d   = nb_col;
          hline_d = nb_hline;
          hcol_d  = nb_hcol;
        end
      end
      M_HCR: begin
        n_res = 2'd1;
        if (b == CH_LF) begin
          r0 = '{ch: CH_LF, line: hline_q, col: hcol_q, err: ERR_NONE,
                 done: 1'b0, last: 1'b0};
          line_d = line_p1;
          col_d  = {{(CW-1){1'b0}}, 1'b1};
          mode_d = M_NORMAL;
        end else begin
          // lone CR: error at the CR, following byte dropped
          r0 = '{ch: CH_NUL, line: hline_q, col: hcol_q, err: ERR_CTRL,
                 done: 1'b1, last: 1'b0};
          mode_d = M_HALTED;
        end
      end
      M_COMMENT, M_CSTAR: begin
        if (b == CH_NUL) begin
          n_res = 2'd1;
          r0 = '{ch: CH_NUL, line: line_q, col: col_q, err: ERR_OPEN,
                 done: 1'b1, last: 1'b0};
          mode_d = M_HALTED;
        end else if (mode_q == M_CSTAR && b == CH_SLASH) begin
          col_d  = col_p1;
          mode_d = M_NORMAL;
        end else if (b == CH_STAR) begin
          col_d  = col_p1;
          mode_d = M_CSTAR;
        end else if (b == CH_CR) begin
          hline_d = line_q;
          hcol_d  = col_q;
          mode_d  = M_CCR;
        end else if (b == CH_LF) begin
          line_d = line_p1;
          col_d  = {{(CW-1){1'b0}}, 1'b1};
          mode_d = M_COMMENT;
        end else if (b == CH_TAB) begin
          col_d  = col_tab;
          mode_d = M_COMMENT;
        end else if (is_bad) begin
          n_res = 2'd1;
          r0 = '{ch: CH_NUL, line: line_q, col: col_q, err: ERR_CTRL,
                 done: 1'b1, last: 1'b0};
          mode_d = M_HALTED;
        end else begin
          col_d  = col_adv;
          mode_d = M_COMMENT;
        end
      end
      M_CCR: begin
        if (b == CH_LF) begin
          line_d = line_p1;
          col_d  = {{(CW-1){1'b0}}, 1'b1};
          mode_d = M_COMMENT;
        end else begin
          n_res = 2'd1;
          r0 = '{ch: CH_NUL, line: hline_q, col: hcol_q, err: ERR_CTRL,
                 done: 1'b1, last: 1'b0};
          mode_d = M_HALTED;
        end
      end
      default: begin
        mode_d = M_HALTED;
      end
    endcase

    // mark the final result of this byte
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Output queue: two entries. A request is taken only when the queue is empty
  // after this cycle's pop, so both results of a byte always fit, and the
  // queue then restarts at entry 0.
  // ---------------------------------------------------------------------------
  result_t    ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d;
  logic       pop, in_acc;
  result_t    head;

  assign head        = ent_q[rd_q];
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;

  assign char_out_o    = head.ch;
  assign line_no_o     = head.line;
  assign column_no_o   = head.col;
  assign error_code_o  = head.err;
  assign done_res_o    = head.done;
  assign last_of_run_o = head.last;

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (in_acc) begin
      cnt_d = n_res;
      rd_d  = 1'b0;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      rd_d  = ~rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_NORMAL;
      line_q  <= {{(LW-1){1'b0}}, 1'b1};
      col_q   <= {{(CW-1){1'b0}}, 1'b1};
      hline_q <= {{(LW-1){1'b0}}, 1'b1};
      hcol_q  <= {{(CW-1){1'b0}}, 1'b1};
      cnt_q   <= 2'd0;
      rd_q    <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      if (in_acc) begin
        mode_q  <= mode_d;
        line_q  <= line_d;
        col_q   <= col_d;
        hline_q <= hline_d;
        hcol_q  <= hcol_d;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ent_q[0] <= r0;
      ent_q[1] <= r1;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue count out of range");

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_q == M_HALTED) |=> (cnt_q == 2'd0))
    else $error("result produced while halted");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> last_of_run_o)
    else $error("done result is not the last of its byte");

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_no_o != '0 && column_no_o != '0))
    else $error("zero line or column on a result");

endmodule

`default_nettype wire
